>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge while out of reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that a condition on one edge implies a consequence on the next edge.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/mdpad_pkg.sv
`default_nettype none

package mdpad_pkg;

    // Input kind carried on s_tuser.
    typedef enum logic {
        OP_DATA   = 1'b0,
        OP_FINISH = 1'b1
    } op_t;

    localparam int WORD_W      = 32;
    localparam int INDEX_W     = 4;
    localparam int COUNT_W     = 64;
    localparam int PARTIAL_W   = 24;
    localparam int PAD_POS_W   = 5;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 40;
    localparam int M_TUSER_W   = 2;

    // Last byte offset in a block that still leaves room for the length words.
    localparam logic [5:0] LAST_LENGTH_FREE_BYTE = 6'd55;
    // Byte offset within a 64-byte block.
    localparam logic [5:0] BLOCK_BYTE_MASK       = 6'd63;
    // Bit position of the count where the high length word starts.
    localparam int         HIGH_LENGTH_SHIFT     = 29;

    localparam logic [7:0]         MARKER_BYTE = 8'h80;
    localparam logic [INDEX_W-1:0] LAST_INDEX  = 4'd15;
    localparam logic [INDEX_W-1:0] LEN_LO_IDX  = 4'd14;
    localparam logic [1:0]         LAST_LANE   = 2'd3;

endpackage

`default_nettype wire

>>> hw/rtl/md_style_block_padder_le.sv
// Message padding front end for an MD4-family hash, little-endian words.
//
// Input channel (s_*): one beat per message byte (s_tuser = data) or one
// finish beat (s_tuser = finish, s_tdata ignored). Bytes are packed four to
// a 32-bit word, first byte in the low bits. A byte that completes a word
// produces one output beat in the cycle after it is taken.
// Output channel (m_*): one beat per word with its index in the 16-word
// block, a block-end flag, a message-end flag and tlast on the last beat
// caused by an input beat. A finish beat produces 3 to 18 beats: the partial
// word with the 0x80 marker, zero fill, an extra block when 56 or more bytes
// of the block are used, and the bit length (low word first) in words 14/15.
// Throughput, unless the output stalls: one data byte per cycle. After a
// finish beat the input is held off until the last padding beat is loaded,
// one word per cycle; the first padding beat passes the active flag and
// then the output register. Reset clears the byte count, partial word,
// padding active and marker flags and output valid. A receiver stall holds
// the output beat and drops s_tready, so no beat is lost or repeated.
`default_nettype none
`include "assert_macros.svh"

module md_style_block_padder_le
    import mdpad_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Input channel
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // [7:0] data_byte
    input  wire logic                 s_tuser,   // [0] op (0 data, 1 finish)
    // Output channel
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // [31:0] block_word, [35:32] word_index
    output logic [M_TUSER_W-1:0]      m_tuser,   // [0] block_end, [1] message_end
    output logic                      m_tlast    // run_last
);

    // Message state
    logic [PARTIAL_W-1:0] partial_reg, partial_next;
    logic [COUNT_W-1:0]   count_reg, count_next;

    // Padding sequencer: position runs over up to two blocks (bit 4 = extra block)
    logic                 pad_active_reg, pad_active_next;
    logic [PAD_POS_W-1:0] pad_pos_reg, pad_pos_next;
    logic                 extra_reg, extra_next;
    logic                 marker_due_reg, marker_due_next;
    logic [WORD_W-1:0]    marker_reg, marker_next;
    logic [COUNT_W-1:0]   len_reg, len_next;

    // Output register
    logic                 m_valid_reg, m_valid_next;
    logic [WORD_W-1:0]    m_word_reg, m_word_next;
    logic [INDEX_W-1:0]   m_index_reg, m_index_next;
    logic                 m_bend_reg, m_bend_next;
    logic                 m_mend_reg, m_mend_next;
    logic                 m_last_reg, m_last_next;

    logic                 slot_free;
    logic                 s_accept;
    op_t                  s_op;
    logic [7:0]           s_byte;
    logic [1:0]           lane;
    logic [INDEX_W-1:0]   word_idx;
    logic [5:0]           block_pos;
    logic [WORD_W-1:0]    marker_word;
    logic [INDEX_W-1:0]   pad_idx;
    logic                 pad_len_block;
    logic                 pad_final;
    logic [WORD_W-1:0]    pad_word;

    assign slot_free = !m_valid_reg || m_tready;
    assign s_tready  = !pad_active_reg && slot_free;
    assign s_accept  = s_tvalid && s_tready;
    assign s_op      = op_t'(s_tuser);
    assign s_byte    = s_tdata[7:0];

    assign lane      = count_reg[1:0];
    assign word_idx  = count_reg[5:2];
    assign block_pos = count_reg[5:0] & BLOCK_BYTE_MASK;

    // Marker word: keep the bytes taken so far, put 0x80 in the next lane
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            if (j < int'(lane)) begin
                marker_word[8*j +: 8] = partial_reg[8*j +: 8];
            end else if (j == int'(lane)) begin
                marker_word[8*j +: 8] = MARKER_BYTE;
            end else begin
                marker_word[8*j +: 8] = 8'h00;
            end
        end
    end

    // Padding word for the current sequencer position
    assign pad_idx       = pad_pos_reg[INDEX_W-1:0];
    assign pad_len_block = (pad_pos_reg[PAD_POS_W-1] == extra_reg);
    assign pad_final     = pad_len_block && (pad_idx == LAST_INDEX);

    always_comb begin
        priority if (marker_due_reg) begin
            pad_word = marker_reg;
        end else if (pad_len_block && pad_idx == LEN_LO_IDX) begin
            pad_word = len_reg[WORD_W-1:0];
        end else if (pad_len_block && pad_idx == LAST_INDEX) begin
            pad_word = len_reg[COUNT_W-1:WORD_W];
        end else begin
            pad_word = '0;
        end
    end

    always_comb begin
        partial_next    = partial_reg;
        count_next      = count_reg;
        pad_active_next = pad_active_reg;
        pad_pos_next    = pad_pos_reg;
        extra_next      = extra_reg;
        marker_due_next = marker_due_reg;
        marker_next     = marker_reg;
        len_next        = len_reg;

        m_valid_next = m_valid_reg && !m_tready;
        m_word_next  = m_word_reg;
        m_index_next = m_index_reg;
        m_bend_next  = m_bend_reg;
        m_mend_next  = m_mend_reg;
        m_last_next  = m_last_reg;

        if (pad_active_reg && slot_free) begin
            // Emit one padding word, advance the sequencer
            m_valid_next    = 1'b1;
            m_word_next     = pad_word;
            m_index_next    = pad_idx;
            m_bend_next     = (pad_idx == LAST_INDEX);
            m_mend_next     = pad_final;
            m_last_next     = pad_final;
            marker_due_next = 1'b0;
            pad_pos_next    = pad_pos_reg + PAD_POS_W'(1);
            if (pad_final) begin
                pad_active_next = 1'b0;
            end
        end else if (s_accept) begin
            unique case (s_op)
                OP_DATA: begin
                    count_next = count_reg + COUNT_W'(1);
                    if (lane == LAST_LANE) begin
                        m_valid_next = 1'b1;
                        m_word_next  = {s_byte, partial_reg};
                        m_index_next = word_idx;
                        m_bend_next  = (word_idx == LAST_INDEX);
                        m_mend_next  = 1'b0;
                        m_last_next  = 1'b1;
                        partial_next = '0;
                    end else begin
                        partial_next[8*lane +: 8] = s_byte;
                    end
                end
                OP_FINISH: begin
                    // Capture the tail of the message, clear for the next one
                    pad_active_next = 1'b1;
                    pad_pos_next    = {1'b0, word_idx};
                    extra_next      = (block_pos > LAST_LENGTH_FREE_BYTE);
                    marker_due_next = 1'b1;
                    marker_next     = marker_word;
                    len_next        = {count_reg[COUNT_W-4:0], 3'b000};
                    partial_next    = '0;
                    count_next      = '0;
                end
                default: begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_reg    <= '0;
            count_reg      <= '0;
            pad_active_reg <= 1'b0;
            marker_due_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            partial_reg    <= partial_next;
            count_reg      <= count_next;
            pad_active_reg <= pad_active_next;
            marker_due_reg <= marker_due_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge aclk) begin
        pad_pos_reg <= pad_pos_next;
        extra_reg   <= extra_next;
        marker_reg  <= marker_next;
        len_reg     <= len_next;
        m_word_reg  <= m_word_next;
        m_index_reg <= m_index_next;
        m_bend_reg  <= m_bend_next;
        m_mend_reg  <= m_mend_next;
        m_last_reg  <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - WORD_W - INDEX_W){1'b0}}, m_index_reg, m_word_reg};
    assign m_tuser  = {m_mend_reg, m_bend_reg};
    assign m_tlast  = m_last_reg;

    // The length word ends the padded message: last word of a block, and tlast.
    `ASSERT_ALWAYS(a_mend_at_block_end, aclk, aresetn, !(m_valid_reg && m_mend_reg) || (m_last_reg && m_bend_reg && m_index_reg == LAST_INDEX), "message end off the last block word")
    // While padding runs, no input beat may be taken.
    `ASSERT_ALWAYS(a_no_input_while_padding, aclk, aresetn, !(pad_active_reg && s_tready), "input taken during padding")
    // A finish beat starts the sequencer with a cleared message state.
    `ASSERT_NEXT(a_finish_clears, aclk, aresetn, s_accept && s_op == OP_FINISH, pad_active_reg && marker_due_reg && count_reg == '0 && partial_reg == '0, "finish did not start padding")

endmodule

`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import mdpad_pkg::*;

    // One expected output beat: a packed message or padding word.
    typedef struct packed {
        logic [WORD_W-1:0]  word;
        logic [INDEX_W-1:0] index;
        logic               block_end;
        logic               message_end;
        logic               run_last;
    } pad_word_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;     // [7:0] data_byte
    logic                 s_tuser  = OP_DATA; // [0] op
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;           // [31:0] block_word, [35:32] word_index
    logic [M_TUSER_W-1:0] m_tuser;           // [0] block_end, [1] message_end
    logic                 m_tlast;           // run_last

    // Shadow of the padder state, advanced on every accepted input beat.
    logic [PARTIAL_W-1:0] pend_bytes = '0;
    logic [COUNT_W-1:0]   msg_bytes  = '0;
    pad_word_t            expected_words[$];

    int error_count   = 0;
    bit tx_idle_on    = 1'b1;
    bit rx_idle_on    = 1'b1;
    int hold_off_left = 0;   // set by a test, counted down by the receiver
    int rx_gap_left   = 0;

    md_style_block_padder_le dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #10 aclk = ~aclk;

    // Hard stop well beyond the slowest legal run.
    initial begin
        #50_000_000;
        $display("tb: failure");
        $finish;
    end

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < 100) $display("%0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic push_word(input logic [WORD_W-1:0] w, input logic [INDEX_W-1:0] idx,
                             input logic mend, input logic rlast);
        pad_word_t pw;
        pw.word        = w;
        pw.index       = idx;
        pw.block_end   = (idx == LAST_INDEX);
        pw.message_end = mend;
        pw.run_last    = rlast;
        expected_words.push_back(pw);
    endtask

    // Advance the shadow state by one input beat and queue the words it emits.
    task automatic predict_padding(input op_t op, input logic [7:0] b);
        logic [1:0]        lane;
        logic [5:0]        pos;
        logic [WORD_W-1:0] marker;
        logic [WORD_W-1:0] len_lo;
        logic [WORD_W-1:0] len_hi;
        logic [WORD_W-1:0] w;
        int                first;
        int                last_slot;
        int                slot;
        int                j;
        lane = msg_bytes[1:0];
        if (op == OP_DATA) begin
            if (lane == LAST_LANE) begin
                // Fourth byte closes the word: emit it, first byte lowest.
                push_word({b, pend_bytes}, msg_bytes[5:2], 1'b0, 1'b1);
                pend_bytes = '0;
            end else begin
                pend_bytes[8*lane +: 8] = b;
            end
            msg_bytes = msg_bytes + 1'b1;
        end else begin
            pos    = msg_bytes[5:0] & BLOCK_BYTE_MASK;
            first  = pos[5:2];
            // Past the last free byte the length spills into an extra block.
            last_slot = (pos > LAST_LENGTH_FREE_BYTE) ? 31 : 15;
            len_lo = {msg_bytes[WORD_W-4:0], 3'b000};
            len_hi = msg_bytes[HIGH_LENGTH_SHIFT +: WORD_W];
            marker = '0;
            for (j = 0; j < lane; j++) marker[8*j +: 8] = pend_bytes[8*j +: 8];
            marker[8*lane +: 8] = MARKER_BYTE;
            for (slot = first; slot <= last_slot; slot++) begin
                if (slot == first) w = marker;
                else if (slot == last_slot - 1) w = len_lo;
                else if (slot == last_slot) w = len_hi;
                else w = '0;
                push_word(w, slot[3:0], slot == last_slot, slot == last_slot);
            end
            pend_bytes = '0;
            msg_bytes  = '0;
        end
    endtask

    // Receiver: check each accepted beat against the oldest expectation, then
    // pick the next tready from the hold-off counter and the random gaps.
    always @(posedge aclk) begin
        pad_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_words.size() == 0) begin
                report_mismatch($sformatf("unexpected beat tdata 0x%0h", m_tdata));
            end else begin
                want = expected_words.pop_front();
                if (m_tdata[WORD_W-1:0] !== want.word)
                    report_mismatch($sformatf("block_word got 0x%0h want 0x%0h",
                                              m_tdata[WORD_W-1:0], want.word));
                if (m_tdata[WORD_W +: INDEX_W] !== want.index)
                    report_mismatch($sformatf("word_index got %0d want %0d",
                                              m_tdata[WORD_W +: INDEX_W], want.index));
                if (m_tuser[0] !== want.block_end)
                    report_mismatch($sformatf("block_end got %b want %b",
                                              m_tuser[0], want.block_end));
                if (m_tuser[1] !== want.message_end)
                    report_mismatch($sformatf("message_end got %b want %b",
                                              m_tuser[1], want.message_end));
                if (m_tlast !== want.run_last)
                    report_mismatch($sformatf("run_last got %b want %b",
                                              m_tlast, want.run_last));
            end
        end
        if (hold_off_left > 0) begin
            hold_off_left--;
            m_tready <= 1'b0;
        end else if (rx_gap_left > 0) begin
            rx_gap_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            rx_gap_left = rx_idle_on ? idle_gap() : 0;
        end
    end

    // Offer one beat, hold it until taken, then maybe idle the input.
    task automatic send_beat(input op_t op, input logic [7:0] b);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_padding(op, b);
        gap = tx_idle_on ? idle_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_message(input int len);
        int i;
        for (i = 0; i < len; i++) send_beat(OP_DATA, 8'($urandom_range(0, 255)));
        send_beat(OP_FINISH, 8'($urandom_range(0, 255)));
    endtask

    // Drop valid and wait until every queued word has come out.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
    endtask

    // Empty messages and finishes at every byte lane, byte extremes, no idling.
    task automatic test_directed_tails();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        send_beat(OP_FINISH, 8'hFF);   // empty message, data byte ignored
        send_beat(OP_FINISH, 8'h00);   // back to back
        send_beat(OP_DATA, 8'h00);
        send_beat(OP_DATA, 8'hFF);
        send_beat(OP_DATA, 8'hA5);
        send_beat(OP_DATA, 8'h5A);
        send_beat(OP_FINISH, 8'h55);   // marker at the start of a word
        send_beat(OP_DATA, 8'hFF);
        send_beat(OP_FINISH, 8'h00);   // marker in lane 1
        send_beat(OP_DATA, 8'h80);
        send_beat(OP_DATA, 8'h7F);
        send_beat(OP_FINISH, 8'hAA);   // marker in lane 2
        send_beat(OP_DATA, 8'h01);
        send_beat(OP_DATA, 8'hFE);
        send_beat(OP_DATA, 8'h33);
        send_beat(OP_FINISH, 8'hFF);   // marker in the top lane
        wait_drained();
    endtask

    // Stall the output long enough that the input backs up, with 56 bytes so
    // that the length lands in an extra block.
    task automatic test_receiver_hold_off();
        tx_idle_on    = 1'b0;
        rx_idle_on    = 1'b1;
        hold_off_left = 400;
        send_message(56);
        wait_drained();
    endtask

    // Last byte offset that still fits the length; then pause until idle.
    task automatic test_sender_pause();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        send_message(55);
        wait_drained();
    endtask

    // Messages of random length and content, mostly short, some past a block.
    task automatic test_random_messages();
        int sent;
        int len;
        sent = 0;
        while (sent < 80) begin
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) < 3) len = $urandom_range(56, 70);
            else len = $urandom_range(0, 12);
            send_message(len);
            sent += len + 1;
        end
        wait_drained();
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_tails();
        test_receiver_hold_off();
        test_sender_pause();
        test_random_messages();
        // Let any stray beat surface before judging.
        repeat (20) @(posedge aclk);
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
